### hw/rtl/mailbox_ring_queue_top_macros.svh
// ----------------------------------------------------------------------------
// mailbox_ring_queue_top_macros.svh
// Assertion macros shared by the mailbox ring queue RTL.
// ----------------------------------------------------------------------------
`ifndef MAILBOX_RING_QUEUE_TOP_MACROS_SVH
`define MAILBOX_RING_QUEUE_TOP_MACROS_SVH

// same-cycle implication under reset
`define MRQ_ASSERT_NOW(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication under reset
`define MRQ_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### hw/rtl/mrq_pkg.sv
// ----------------------------------------------------------------------------
// mrq_pkg
// Shared types and constants of the mailbox ring queue.
// ----------------------------------------------------------------------------
package mrq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int CMD_W  = 2;
    localparam int MSG_W  = 32;
    localparam int CFG_W  = 5;
    localparam int FILL_W = 5;
    localparam int STAT_W = 1;
    localparam int OUT_TDATA_W = ((MSG_W + FILL_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_SEND = 2'd0,
        CMD_JAM  = 2'd1,
        CMD_RECV = 2'd2
    } cmd_t;

    localparam logic [STAT_W-1:0] STAT_DONE    = 1'b0;
    localparam logic [STAT_W-1:0] STAT_REFUSED = 1'b1;

endpackage

### hw/rtl/mailbox_ring_queue_top.sv
// ----------------------------------------------------------------------------
// mailbox_ring_queue_top
// Message mailbox held as a ring of slots in one synchronous memory, with a
// head index and fill count in registers. Send, jam and receive per beat.
//
//   channel | dir | handshake                   | payload
//   --------+-----+-----------------------------+-------------------------------
//   s_axis  | in  | s_axis_tvalid/s_axis_tready | tuser command, tdata message_in
//   m_axis  | out | m_axis_tvalid/m_axis_tready | tuser status,
//           |     |                             | tdata message_out, fill_level
//   cfg     | in  | cfg_valid/cfg_ready         | cfg_data capacity
//
// One beat accepted per cycle unless the output stalls; a result is held in
// the result stage beside the registered slot memory read, then in the output
// register. Head and count update in the accept cycle, so back-to-back
// accesses to the same slot need no forwarding.
// Reset: capacity DEPTH, queue empty; slot contents undefined until written.
// A stalled output holds the result stage, which then stalls the input.
// ----------------------------------------------------------------------------
module mailbox_ring_queue_top #(
    parameter int DEPTH     = mrq_pkg::DEPTH_DEF,
    parameter int WORD_BITS = mrq_pkg::WORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [mrq_pkg::MSG_W-1:0]        s_axis_tdata,  // [31:0] message_in
    input  logic [mrq_pkg::CMD_W-1:0]        s_axis_tuser,  // [1:0] command
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [mrq_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [31:0] message_out,
                                                            // [36:32] fill_level
    output logic [mrq_pkg::STAT_W-1:0]       m_axis_tuser,  // [0] status
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mrq_pkg::CFG_W-1:0]        cfg_data       // [4:0] capacity
);
    import mrq_pkg::*;

    localparam int CAP_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SUM_W = CAP_W + 1;

    logic [WORD_BITS-1:0] slots_mem [DEPTH];

    logic [CAP_W-1:0]     cap_reg,   cap_next;
    logic [IDX_W-1:0]     head_reg,  head_next;
    logic [CAP_W-1:0]     count_reg, count_next;
    logic [WORD_BITS-1:0] rd_reg;

    logic                 p1_valid_reg;
    logic [STAT_W-1:0]    p1_status_reg;
    logic                 p1_rx_reg;
    logic [CAP_W-1:0]     p1_count_reg;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [STAT_W-1:0]      out_status_reg;

    logic                 in_fire, cfg_fire, p1_adv, out_free;
    logic                 mem_we, mem_re, rx_ok;
    logic [STAT_W-1:0]    status;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SUM_W-1:0]     tail_sum, tail_pos;
    logic [IDX_W-1:0]     head_dec, head_wrap;
    logic [CAP_W-1:0]     head_inc;
    logic [WORD_BITS-1:0] wdata;

    assign cfg_ready     = 1'b1;
    assign cfg_fire      = cfg_valid & cfg_ready;
    assign out_free      = ~out_valid_reg | m_axis_tready;
    assign p1_adv        = p1_valid_reg & out_free;
    assign s_axis_tready = ~p1_valid_reg | p1_adv;
    assign in_fire       = s_axis_tvalid & s_axis_tready;

    assign wdata    = WORD_BITS'(s_axis_tdata);
    assign tail_sum = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_pos = (tail_sum >= SUM_W'(cap_reg)) ? tail_sum - SUM_W'(cap_reg) : tail_sum;
    assign head_dec = (head_reg == '0) ? IDX_W'(cap_reg - 1'b1) : head_reg - 1'b1;
    assign head_inc = CAP_W'(head_reg) + 1'b1;
    assign head_wrap = (head_inc >= cap_reg) ? '0 : IDX_W'(head_inc);

    always_comb
    begin
        cap_next   = cap_reg;
        head_next  = head_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_waddr  = head_reg;
        status     = STAT_REFUSED;
        rx_ok      = 1'b0;
        if (cfg_fire)
        begin
            // clamp and empty the queue
            cap_next   = (int'(cfg_data) > DEPTH) ? CAP_W'(DEPTH) : CAP_W'(cfg_data);
            head_next  = '0;
            count_next = '0;
        end
        else if (in_fire && cap_reg != '0)
        begin
            unique case (s_axis_tuser)
                CMD_SEND:
                begin
                    if (count_reg < cap_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = tail_pos[IDX_W-1:0];
                        count_next = count_reg + 1'b1;
                        status     = STAT_DONE;
                    end
                end
                CMD_JAM:
                begin
                    if (count_reg < cap_reg)
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = head_dec;
                        head_next  = head_dec;
                        count_next = count_reg + 1'b1;
                        status     = STAT_DONE;
                    end
                end
                CMD_RECV:
                begin
                    if (count_reg != '0)
                    begin
                        mem_re     = 1'b1;
                        rx_ok      = 1'b1;
                        head_next  = head_wrap;
                        count_next = count_reg - 1'b1;
                        status     = STAT_DONE;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slots_mem[mem_waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_reg <= slots_mem[head_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_W'(DEPTH);
            head_reg      <= '0;
            count_reg     <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg   <= cap_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (in_fire)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_adv)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p1_status_reg <= status;
            p1_rx_reg     <= rx_ok;
            p1_count_reg  <= count_next;
        end
        if (p1_adv)
        begin
            out_status_reg <= p1_status_reg;
            out_data_reg   <= {(OUT_TDATA_W - MSG_W - FILL_W)'(0),
                               FILL_W'(p1_count_reg),
                               p1_rx_reg ? MSG_W'(rd_reg) : MSG_W'(0)};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

`include "mailbox_ring_queue_top_macros.svh"

    `MRQ_ASSERT_NOW(a_count_in_cap, clk, rst_n, 1'b1, count_reg <= cap_reg,
        "fill count beyond capacity")
    `MRQ_ASSERT_NOW(a_head_in_cap, clk, rst_n, cap_reg != '0, CAP_W'(head_reg) < cap_reg,
        "head outside ring")
    `MRQ_ASSERT_NEXT(a_refused_holds, clk, rst_n,
        in_fire && !cfg_fire && status == STAT_REFUSED,
        count_reg == $past(count_reg) && head_reg == $past(head_reg),
        "refused beat changed queue")
    `MRQ_ASSERT_NEXT(a_rd_held, clk, rst_n, p1_valid_reg && p1_rx_reg && !p1_adv,
        $stable(rd_reg), "read data lost while stalled")

endmodule

### tb/mailbox_ring_queue_top_test.sv
// ----------------------------------------------------------------------------
// mailbox_ring_queue_top_test
// Self-checking bench for the mailbox ring queue. A directed table runs
// through refusals, jam ordering, the capacity extremes and the undefined
// command. Random phases follow, each at its own capacity, with fill, drain
// and mixed runs of beats. Both stream sides idle at random, and the output
// side holds off once for a long stretch so that the block stalls its input.
// Each result is compared with a typed table reply or a model of ring, head, count.
// ----------------------------------------------------------------------------
module mailbox_ring_queue_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import mrq_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RING_SLOTS   = DEPTH_DEF;
    localparam int RANDOM_BEATS = 1630;
    localparam int HOLD_CYCLES  = 300;
    localparam int HOLD_AFTER   = 400;
    localparam int STALL_LIMIT  = 2000;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [MSG_W-1:0]  word;
        logic [FILL_W-1:0] fill;
    } mbox_reply_t;

    typedef struct packed {
        logic              is_cfg;
        logic [CFG_W-1:0]  cap;
        logic [CMD_W-1:0]  cmd;
        logic [MSG_W-1:0]  word;
        logic              typed;
        mbox_reply_t       reply;
    } dir_row_t;

    typedef enum int {FILL_UP, DRAIN_DOWN, MIXED} fill_bias_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [MSG_W-1:0]        s_axis_tdata;   // [31:0] message_in
    logic [CMD_W-1:0]        s_axis_tuser;   // [1:0] command
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;   // [31:0] message_out, [36:32] fill_level
    logic [STAT_W-1:0]       m_axis_tuser;   // [0] status
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [CFG_W-1:0]        cfg_data;       // [4:0] capacity

    logic [MSG_W-1:0] slot_word [RING_SLOTS];
    int unsigned      ring_head;
    int unsigned      ring_count;
    int unsigned      ring_cap;

    mbox_reply_t pending_replies[$];
    int          mismatches;
    int          results_seen;
    int          stall_cycles;
    bit          quiet_phase;

    dir_row_t dir_rows [27] = '{
        '{1'b0, 5'd0,  CMD_RECV,   32'h0000_0000, 1'b1, '{STAT_REFUSED, 32'h0, 5'd0}},
        '{1'b0, 5'd0,  CMD_UNUSED, 32'hFFFF_FFFF, 1'b1, '{STAT_REFUSED, 32'h0, 5'd0}},
        '{1'b0, 5'd0,  CMD_SEND,   32'hFFFF_FFFF, 1'b1, '{STAT_DONE, 32'h0, 5'd1}},
        '{1'b0, 5'd0,  CMD_JAM,    32'h0000_0000, 1'b1, '{STAT_DONE, 32'h0, 5'd2}},
        '{1'b0, 5'd0,  CMD_RECV,   32'h0000_0000, 1'b1, '{STAT_DONE, 32'h0, 5'd1}},
        '{1'b0, 5'd0,  CMD_RECV,   32'h0000_0000, 1'b1,
          '{STAT_DONE, 32'hFFFF_FFFF, 5'd0}},
        '{1'b1, 5'd1,  CMD_SEND,   32'h0000_0000, 1'b0, '0},
        '{1'b0, 5'd0,  CMD_SEND,   32'hA5A5_A5A5, 1'b1, '{STAT_DONE, 32'h0, 5'd1}},
        '{1'b0, 5'd0,  CMD_SEND,   32'h3C3C_3C3C, 1'b1, '{STAT_REFUSED, 32'h0, 5'd1}},
        '{1'b0, 5'd0,  CMD_JAM,    32'hC3C3_C3C3, 1'b1, '{STAT_REFUSED, 32'h0, 5'd1}},
        '{1'b0, 5'd0,  CMD_RECV,   32'h0000_0000, 1'b1,
          '{STAT_DONE, 32'hA5A5_A5A5, 5'd0}},
        '{1'b0, 5'd0,  CMD_JAM,    32'h5A5A_5A5A, 1'b0, '0},
        '{1'b0, 5'd0,  CMD_RECV,   32'h0000_0000, 1'b0, '0},
        '{1'b1, 5'd0,  CMD_SEND,   32'h0000_0000, 1'b0, '0},
        '{1'b0, 5'd0,  CMD_SEND,   32'h0000_0001, 1'b1, '{STAT_REFUSED, 32'h0, 5'd0}},
        '{1'b0, 5'd0,  CMD_JAM,    32'h0000_0002, 1'b1, '{STAT_REFUSED, 32'h0, 5'd0}},
        '{1'b0, 5'd0,  CMD_RECV,   32'h0000_0000, 1'b1, '{STAT_REFUSED, 32'h0, 5'd0}},
        '{1'b1, 5'd2,  CMD_SEND,   32'h0000_0000, 1'b0, '0},
        '{1'b0, 5'd0,  CMD_JAM,    32'h1234_5678, 1'b0, '0},
        '{1'b0, 5'd0,  CMD_JAM,    32'h8765_4321, 1'b0, '0},
        '{1'b0, 5'd0,  CMD_SEND,   32'h0000_0000, 1'b0, '0},
        '{1'b0, 5'd0,  CMD_RECV,   32'h0000_0000, 1'b0, '0},
        '{1'b0, 5'd0,  CMD_RECV,   32'h0000_0000, 1'b0, '0},
        '{1'b1, 5'd31, CMD_SEND,   32'h0000_0000, 1'b0, '0},
        '{1'b0, 5'd0,  CMD_SEND,   32'hDEAD_BEEF, 1'b0, '0},
        '{1'b0, 5'd0,  CMD_RECV,   32'h0000_0000, 1'b0, '0},
        '{1'b0, 5'd0,  CMD_UNUSED, 32'h0000_0000, 1'b0, '0}
    };

    mailbox_ring_queue_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic mbox_reply_t mailbox_access(input logic [CMD_W-1:0] cmd,
                                                   input logic [MSG_W-1:0] word);
        mbox_reply_t reply;
        int unsigned tail;
        reply.status = STAT_REFUSED;
        reply.word   = '0;
        if (ring_cap != 0 && ring_head < ring_cap && ring_count <= ring_cap)
        begin
            if (cmd == CMD_SEND && ring_count < ring_cap)
            begin
                tail = ring_head + ring_count;
                if (tail >= ring_cap)
                    tail = tail - ring_cap;
                slot_word[tail] = word;
                ring_count++;
                reply.status = STAT_DONE;
            end
            else if (cmd == CMD_JAM && ring_count < ring_cap)
            begin
                ring_head = (ring_head == 0) ? ring_cap - 1 : ring_head - 1;
                slot_word[ring_head] = word;
                ring_count++;
                reply.status = STAT_DONE;
            end
            else if (cmd == CMD_RECV && ring_count != 0)
            begin
                reply.word = slot_word[ring_head];
                ring_head++;
                if (ring_head >= ring_cap)
                    ring_head = 0;
                ring_count--;
                reply.status = STAT_DONE;
            end
        end
        reply.fill = ring_count[FILL_W-1:0];
        return reply;
    endfunction

    function automatic int pick_idle_gap();
        int r;
        if (quiet_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic report_mismatch(input string what, input logic [MSG_W-1:0] got,
                                   input logic [MSG_W-1:0] want);
        mismatches++;
        if (mismatches <= 100)
            $display("%0t ns mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    // call and return at a falling edge
    task automatic offer_beat(input logic [CMD_W-1:0] cmd, input logic [MSG_W-1:0] word,
                              input logic typed, input mbox_reply_t typed_reply);
        mbox_reply_t predicted;
        int idle;
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = word;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predicted = mailbox_access(cmd, word);
        pending_replies.push_back(typed ? typed_reply : predicted);
        @(negedge clk);
        idle = pick_idle_gap();
        if (idle > 0)
        begin
            s_axis_tvalid = 1'b0;
            s_axis_tuser  = CMD_W'($urandom_range(0, 3));
            s_axis_tdata  = $urandom();
            repeat (idle) @(negedge clk);
        end
    endtask

    // drain first, then write with the queue idle
    task automatic write_capacity(input logic [CFG_W-1:0] value);
        s_axis_tvalid = 1'b0;
        while (pending_replies.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        ring_cap   = (value > RING_SLOTS) ? RING_SLOTS : value;
        ring_head  = 0;
        ring_count = 0;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    always @(posedge clk)
    begin
        mbox_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_replies.size() == 0)
                report_mismatch("result with nothing pending", m_axis_tdata[MSG_W-1:0], '0);
            else
            begin
                want = pending_replies.pop_front();
                if (m_axis_tuser !== want.status)
                    report_mismatch("status", MSG_W'(m_axis_tuser), MSG_W'(want.status));
                if (m_axis_tdata[MSG_W-1:0] !== want.word)
                    report_mismatch("message_out", m_axis_tdata[MSG_W-1:0], want.word);
                if (m_axis_tdata[MSG_W +: FILL_W] !== want.fill)
                    report_mismatch("fill_level", MSG_W'(m_axis_tdata[MSG_W +: FILL_W]),
                                    MSG_W'(want.fill));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles = 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                 (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
        begin
            stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("mailbox_ring_queue_top regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        bit held;
        int idle;
        held = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (!held && results_seen >= HOLD_AFTER)
            begin
                held = 1'b1;
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            idle = pick_idle_gap();
            if (idle == 0)
                m_axis_tready = 1'b1;
            else
            begin
                m_axis_tready = 1'b0;
                repeat (idle) @(negedge clk);
                m_axis_tready = 1'b1;
            end
        end
    end

    initial
    begin
        int issued;
        int phase_no;
        int phase_len;
        int run_left;
        int r;
        fill_bias_t bias;
        logic [CMD_W-1:0] cmd;
        logic [MSG_W-1:0] word;
        logic [CFG_W-1:0] next_cap;

        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        quiet_phase   = 1'b0;
        mismatches    = 0;
        results_seen  = 0;
        ring_cap      = RING_SLOTS;
        ring_head     = 0;
        ring_count    = 0;
        bias          = MIXED;
        rst_n         = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_capacity(dir_rows[i].cap);
            else
                offer_beat(dir_rows[i].cmd, dir_rows[i].word, dir_rows[i].typed,
                           dir_rows[i].reply);
        end

        issued   = 0;
        phase_no = 0;
        while (issued < RANDOM_BEATS)
        begin
            case (phase_no)
                0: next_cap = 5'd16;
                1: next_cap = 5'd1;
                2: next_cap = 5'd0;
                3: next_cap = 5'd31;
                4: next_cap = 5'd2;
                5: next_cap = 5'd17;
                default: next_cap = ($urandom_range(0, 5) == 0) ?
                                    CFG_W'($urandom_range(0, 31)) :
                                    CFG_W'($urandom_range(1, 16));
            endcase
            write_capacity(next_cap);
            quiet_phase = ($urandom_range(0, 3) == 0);
            run_left = 0;
            phase_len = (next_cap == 0) ? 30 : int'($urandom_range(80, 200));
            if (phase_len > RANDOM_BEATS - issued)
                phase_len = RANDOM_BEATS - issued;
            repeat (phase_len)
            begin
                if (run_left == 0)
                begin
                    bias     = fill_bias_t'($urandom_range(0, 2));
                    run_left = $urandom_range(4, 40);
                end
                run_left--;
                r = $urandom_range(0, 99);
                if (r < 4)
                    cmd = CMD_UNUSED;
                else if (bias == FILL_UP)
                    cmd = (r < 44) ? CMD_SEND : (r < 80) ? CMD_JAM : CMD_RECV;
                else if (bias == DRAIN_DOWN)
                    cmd = (r < 16) ? CMD_SEND : (r < 28) ? CMD_JAM : CMD_RECV;
                else
                    cmd = (r < 36) ? CMD_SEND : (r < 64) ? CMD_JAM : CMD_RECV;
                r = $urandom_range(0, 99);
                word = (r < 5) ? '0 : (r < 10) ? '1 : $urandom();
                offer_beat(cmd, word, 1'b0, '0);
                issued++;
            end
            phase_no++;
        end

        s_axis_tvalid = 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_replies.size() == 0)
            $display("mailbox_ring_queue_top regression: pass");
        else
            $display("mailbox_ring_queue_top regression: fail");
        $finish;
    end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mrq_pkg.sv
hw/rtl/mailbox_ring_queue_top.sv
tb/mailbox_ring_queue_top_test.sv
